FILE: rtl/vvc_pkg.sv
// shared widths, types and register reset values for the view volume cull block
package vvc_pkg;

    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int SUM_W      = PROD_W + 4;
    localparam int MASK_W     = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 4;
    localparam int NUM_REGS   = 8;
    localparam int NUM_COLS   = 4;
    localparam int NUM_AXES   = 3;
    localparam int NUM_CORNER = 8;
    localparam int COL_W      = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic [1:0]                t_quad;

    localparam logic [CFG_DATA_W-1:0] RST_MREG [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
    };

    // bit 0: c < -w, bit 1: c > w
    function automatic t_quad f_quad(input t_sum c, input t_sum w);
        logic signed [SUM_W:0] s_plus;
        logic signed [SUM_W:0] s_minus;
        s_plus  = {c[SUM_W-1], c} + {w[SUM_W-1], w};
        s_minus = {w[SUM_W-1], w} - {c[SUM_W-1], c};
        return {s_minus[SUM_W], s_plus[SUM_W]};
    endfunction

endpackage

FILE: rtl/vvc_if.sv
// box input and cull result channels
interface vvc_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   box_min_x;
    logic signed [31:0]   box_min_y;
    logic signed [31:0]   box_min_z;
    logic signed [31:0]   box_max_x;
    logic signed [31:0]   box_max_y;
    logic signed [31:0]   box_max_z;
    logic [2:0]           axes_to_test;
    modport source(output valid, box_min_x, box_min_y, box_min_z,
                   box_max_x, box_max_y, box_max_z, axes_to_test, input ready);
    modport sink(input valid, box_min_x, box_min_y, box_min_z,
                 box_max_x, box_max_y, box_max_z, axes_to_test, output ready);
endinterface

interface vvc_out_if;
    logic       valid;
    logic       ready;
    logic       culled;
    logic [2:0] axes_remaining;
    modport source(output valid, culled, axes_remaining, input ready);
    modport sink(input valid, culled, axes_remaining, output ready);
endinterface

FILE: rtl/aabb_view_volume_cull_top.sv
// box against clip volume cull test, four stage pipeline
//  channel  | dir | transfer when       | payload
//  i_box    | in  | valid & ready       | box corners, axes_to_test
//  o_res    | out | valid & ready       | culled, axes_remaining
//  i_cfg_*  | in  | i_cfg_we            | matrix register index and data
// one box per cycle while o_res does not stall, result registered through stages 1 to 4 after the input transfer
// stage 1 multipliers, stage 2 column sums, stage 3 quadrant tests, stage 4 decision
// each stage holds while the one after it is full and stalled
// synchronous reset clears valid bits and loads the identity matrix
module aabb_view_volume_cull_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    vvc_in_if.sink                           i_box,
    vvc_out_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [vvc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [vvc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import vvc_pkg::*;

    logic [CFG_DATA_W-1:0] r_mreg [NUM_REGS];
    t_coord w_m [NUM_COLS][NUM_COLS];
    logic   w_pos [NUM_AXES][NUM_COLS];
    t_sum   w_tr [NUM_COLS];

    t_coord w_lo [NUM_AXES];
    t_coord w_hi [NUM_AXES];

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    t_prod r_plo [NUM_COLS][NUM_AXES];
    t_prod r_phi [NUM_COLS][NUM_AXES];
    logic [MASK_W-1:0] r_mask1, r_mask2, r_mask3, r_mask4, r_min4;

    t_sum r_cor  [NUM_CORNER][NUM_COLS];
    t_sum r_cmin [NUM_COLS];
    t_sum r_cmax [NUM_COLS];

    logic  r_wneg3;
    t_quad r_and1 [NUM_AXES];
    t_quad r_or1  [NUM_AXES];
    t_quad r_and2 [NUM_AXES];
    t_quad r_or2  [NUM_AXES];

    logic r_cull4, r_wc4;
    logic n_cull;
    logic [MASK_W-1:0] n_mask;

    // matrix registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_mreg[i] <= RST_MREG[i];
        end else if (i_cfg_we && i_cfg_idx < CFG_IDX_W'(NUM_REGS)) begin
            r_mreg[i_cfg_idx[COL_W-1:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_COLS; r++) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                w_m[r][c] = r_mreg[r*2 + c/2][(c%2)*COORD_W +: COORD_W];
            end
        end
        for (int r = 0; r < NUM_AXES; r++) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                w_pos[r][c] = !w_m[r][c][COORD_W-1] && (w_m[r][c] != '0);
            end
        end
        for (int c = 0; c < NUM_COLS; c++) begin
            w_tr[c] = {{(SUM_W-COORD_W-16){w_m[3][c][COORD_W-1]}}, w_m[3][c], 16'h0};
        end
    end

    assign w_lo[0] = i_box.box_min_x;
    assign w_lo[1] = i_box.box_min_y;
    assign w_lo[2] = i_box.box_min_z;
    assign w_hi[0] = i_box.box_max_x;
    assign w_hi[1] = i_box.box_max_y;
    assign w_hi[2] = i_box.box_max_z;

    // stall chain
    assign w_en4 = !r_v4 || o_res.ready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign i_box.ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_box.valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_mask1 <= i_box.axes_to_test;
            for (int c = 0; c < NUM_COLS; c++) begin
                for (int r = 0; r < NUM_AXES; r++) begin
                    r_plo[c][r] <= t_prod'(w_m[r][c]) * t_prod'(w_lo[r]);
                    r_phi[c][r] <= t_prod'(w_m[r][c]) * t_prod'(w_hi[r]);
                end
            end
        end
    end

    // stage 2: corner and extreme column values
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_mask2 <= r_mask1;
            for (int c = 0; c < NUM_COLS; c++) begin
                for (int k = 0; k < NUM_CORNER; k++) begin
                    r_cor[k][c] <= w_tr[c]
                        + t_sum'(k[0] ? r_phi[c][0] : r_plo[c][0])
                        + t_sum'(k[1] ? r_phi[c][1] : r_plo[c][1])
                        + t_sum'(k[2] ? r_phi[c][2] : r_plo[c][2]);
                end
                r_cmin[c] <= w_tr[c]
                    + t_sum'(w_pos[0][c] ? r_plo[c][0] : r_phi[c][0])
                    + t_sum'(w_pos[1][c] ? r_plo[c][1] : r_phi[c][1])
                    + t_sum'(w_pos[2][c] ? r_plo[c][2] : r_phi[c][2]);
                r_cmax[c] <= w_tr[c]
                    + t_sum'(w_pos[0][c] ? r_phi[c][0] : r_plo[c][0])
                    + t_sum'(w_pos[1][c] ? r_phi[c][1] : r_plo[c][1])
                    + t_sum'(w_pos[2][c] ? r_phi[c][2] : r_plo[c][2]);
            end
        end
    end

    // stage 3: quadrant tests
    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_mask3 <= r_mask2;
            r_wneg3 <= r_cmax[3][SUM_W-1];
            for (int i = 0; i < NUM_AXES; i++) begin
                r_and1[i] <= f_quad(r_cmin[i], r_cmin[3]) & f_quad(r_cmin[i], r_cmax[3])
                           & f_quad(r_cmax[i], r_cmin[3]) & f_quad(r_cmax[i], r_cmax[3]);
                r_or1[i]  <= f_quad(r_cmin[i], r_cmin[3]) | f_quad(r_cmin[i], r_cmax[3])
                           | f_quad(r_cmax[i], r_cmin[3]) | f_quad(r_cmax[i], r_cmax[3]);
                r_and2[i] <= f_quad(r_cor[0][i], r_cor[0][3]) & f_quad(r_cor[1][i], r_cor[1][3])
                           & f_quad(r_cor[2][i], r_cor[2][3]) & f_quad(r_cor[3][i], r_cor[3][3])
                           & f_quad(r_cor[4][i], r_cor[4][3]) & f_quad(r_cor[5][i], r_cor[5][3])
                           & f_quad(r_cor[6][i], r_cor[6][3]) & f_quad(r_cor[7][i], r_cor[7][3]);
                r_or2[i]  <= f_quad(r_cor[0][i], r_cor[0][3]) | f_quad(r_cor[1][i], r_cor[1][3])
                           | f_quad(r_cor[2][i], r_cor[2][3]) | f_quad(r_cor[3][i], r_cor[3][3])
                           | f_quad(r_cor[4][i], r_cor[4][3]) | f_quad(r_cor[5][i], r_cor[5][3])
                           | f_quad(r_cor[6][i], r_cor[6][3]) | f_quad(r_cor[7][i], r_cor[7][3]);
            end
        end
    end

    // stage 4: axis walk in order, stops at the first outside axis
    always_comb begin
        n_cull = r_wneg3;
        n_mask = r_mask3;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (!n_cull && n_mask[i]) begin
                if (!(r_and1[i] == 2'b00 && r_or1[i] != 2'b00)) begin
                    if (r_or1[i] == 2'b00) n_mask[i] = 1'b0;
                    else                   n_cull = 1'b1;
                end else if (r_or2[i] == 2'b00) begin
                    n_mask[i] = 1'b0;
                end else if (r_and2[i] != 2'b00) begin
                    n_cull = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_cull4 <= n_cull;
            r_mask4 <= n_mask;
            r_min4  <= r_mask3;
            r_wc4   <= r_wneg3;
        end
    end

    assign o_res.valid          = r_v4;
    assign o_res.culled         = r_cull4;
    assign o_res.axes_remaining = r_mask4;

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && w_en4 |=> r_v4) else $error("stage 3 item lost");
    a_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_mask4 & ~r_min4) == '0) else $error("mask bit set");
    a_wcull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_wc4 |-> r_cull4 && r_mask4 == r_min4) else $error("w cull");
endmodule

FILE: tb/tb_cull_scoreboard.sv
// scoreboard and predictor for the box cull test
`timescale 1ns / 100ps

class cull_scoreboard;
    logic [63:0] mreg [8];
    bit [3:0] exp_q[$];
    int errors;

    function new();
        for (int i = 0; i < 8; i++) mreg[i] = vvc_pkg::RST_MREG[i];
        errors = 0;
    endfunction

    function void write_reg(int idx, logic [63:0] d);
        mreg[idx] = d;
    endfunction

    function logic signed [31:0] coef(int r, int c);
        logic [63:0] v;
        v = mreg[(r << 1) | (c >> 1)];
        return (c & 1) ? v[63:32] : v[31:0];
    endfunction

    function logic signed [127:0] col_at(logic signed [31:0] p [3], int c);
        logic signed [127:0] s;
        s = 128'(signed'(coef(3, c))) <<< 16;
        for (int r = 0; r < 3; r++)
            s = s + 128'(signed'(64'(coef(r, c)) * 64'(p[r])));
        return s;
    endfunction

    function logic signed [127:0] extreme_val(logic signed [31:0] lo [3],
                                               logic signed [31:0] hi [3],
                                               int c, bit want_max);
        logic signed [31:0] p [3];
        for (int r = 0; r < 3; r++)
            p[r] = ((coef(r, c) > 0) != want_max) ? lo[r] : hi[r];
        return col_at(p, c);
    endfunction

    function bit [1:0] quadrant(logic signed [127:0] c, logic signed [127:0] w);
        logic signed [127:0] a, b;
        a = c + w;
        b = w - c;
        return {b[127], a[127]};
    endfunction

    function void note_box(logic signed [31:0] lo [3], logic signed [31:0] hi [3],
                           bit [2:0] mask_in);
        bit [2:0] mask;
        bit cul;
        logic signed [127:0] wmin, wmax, cmin, cmax;
        logic signed [31:0] p [3];
        bit [1:0] andb, orb, q;
        mask = mask_in;
        cul = 0;
        wmax = extreme_val(lo, hi, 3, 1);
        if (wmax < 0) cul = 1;
        else begin
            wmin = extreme_val(lo, hi, 3, 0);
            for (int i = 0; i < 3 && !cul; i++) begin
                if (!mask[i]) continue;
                cmin = extreme_val(lo, hi, i, 0);
                cmax = extreme_val(lo, hi, i, 1);
                andb = quadrant(cmin, wmin) & quadrant(cmin, wmax)
                     & quadrant(cmax, wmin) & quadrant(cmax, wmax);
                orb = quadrant(cmin, wmin) | quadrant(cmin, wmax)
                    | quadrant(cmax, wmin) | quadrant(cmax, wmax);
                if (!(andb == 0 && orb != 0)) begin
                    if (orb == 0) begin
                        mask[i] = 0;
                        continue;
                    end
                    cul = 1;
                    break;
                end
                andb = 3;
                orb = 0;
                for (int k = 0; k < 8; k++) begin
                    p[0] = k[0] ? hi[0] : lo[0];
                    p[1] = k[1] ? hi[1] : lo[1];
                    p[2] = k[2] ? hi[2] : lo[2];
                    q = quadrant(col_at(p, i), col_at(p, 3));
                    andb &= q;
                    orb |= q;
                end
                if (orb == 0) mask[i] = 0;
                else if (andb != 0) cul = 1;
            end
        end
        exp_q.push_back({cul, mask});
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_result(bit cul, bit [2:0] rem);
        bit [3:0] e;
        if (exp_q.size() == 0) begin
            report("result with no box pending");
            return;
        end
        e = exp_q.pop_front();
        if (cul !== e[3]) report($sformatf("culled got %0b want %0b", cul, e[3]));
        if (rem !== e[2:0])
            report($sformatf("axes_remaining got %0d want %0d", rem, e[2:0]));
    endtask
endclass

FILE: tb/testbench.sv
// top level testbench for the box cull block
`timescale 1ns / 100ps

module testbench;
    import vvc_pkg::*;

    logic i_clk, i_rst_n, i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int send_idle, recv_idle, cycles;
    bit stim_done;
    cull_scoreboard sb;

    vvc_in_if box_if();
    vvc_out_if res_if();

    aabb_view_volume_cull_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_box(box_if.sink), .o_res(res_if.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
    end

    // sample and check results and accepted boxes at rising edge, result ready changes at falling edge
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.culled, res_if.axes_remaining);
        if (i_rst_n && box_if.valid && box_if.ready)
            sb.note_box('{box_if.box_min_x, box_if.box_min_y, box_if.box_min_z},
                        '{box_if.box_max_x, box_if.box_max_y, box_if.box_max_z},
                        box_if.axes_to_test);
    end

    always @(negedge i_clk)
        res_if.ready <= ($urandom_range(99) >= recv_idle);

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return 32'(int'($urandom_range(20 * 65536)) - 10 * 65536);
        endcase
    endfunction

    task automatic send_box(logic [31:0] lo [3], logic [31:0] hi [3], logic [2:0] m);
        while ($urandom_range(99) < send_idle) begin
            box_if.valid <= 0;
            @(negedge i_clk);
        end
        box_if.valid <= 1;
        box_if.box_min_x <= lo[0];
        box_if.box_min_y <= lo[1];
        box_if.box_min_z <= lo[2];
        box_if.box_max_x <= hi[0];
        box_if.box_max_y <= hi[1];
        box_if.box_max_z <= hi[2];
        box_if.axes_to_test <= m;
        do @(posedge i_clk); while (!box_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random(int n);
        logic [31:0] lo [3], hi [3], t;
        i_cfg_we <= 0;
        for (int j = 0; j < n; j++) begin
            for (int a = 0; a < 3; a++) begin
                lo[a] = rand_coord();
                hi[a] = rand_coord();
                if ($urandom_range(9) != 0 && $signed(lo[a]) > $signed(hi[a])) begin
                    t = lo[a];
                    lo[a] = hi[a];
                    hi[a] = t;
                end
            end
            send_box(lo, hi, 3'($urandom_range(7)));
        end
    endtask

    task automatic drain();
        box_if.valid <= 0;
        while (sb.exp_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [63:0] d);
        i_cfg_we <= 1;
        i_cfg_idx <= CFG_IDX_W'(idx);
        i_cfg_data <= d;
        sb.write_reg(idx, d);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 0;
            default: return 32'(int'($urandom_range(4 * 65536)) - 2 * 65536);
        endcase
    endfunction

    task automatic directed();
        logic [31:0] v [6];
        v = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0001_0000, 32'hffff_0000,
              32'h0000_8000};
        send_box('{32'hffff_8000, 32'hffff_8000, 32'hffff_8000},
                 '{32'h0000_8000, 32'h0000_8000, 32'h0000_8000}, 3'd7);
        send_box('{32'h0003_0000, 32'h0, 32'h0}, '{32'h0004_0000, 32'h0, 32'h0}, 3'd7);
        send_box('{32'hfffe_0000, 32'hfffe_0000, 32'h0}, '{32'h0002_0000,
                 32'h0002_0000, 32'h0}, 3'd7);
        // inverted box
        send_box('{32'h0001_0000, 32'h0001_0000, 32'h0001_0000}, '{32'hffff_0000,
                 32'hffff_0000, 32'hffff_0000}, 3'd5);
        send_box('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, '{32'h7fff_ffff,
                 32'h7fff_ffff, 32'h7fff_ffff}, 3'd7);
        for (int k = 0; k < 8; k++)
            send_box('{v[k % 6], v[(k + 1) % 6], v[(k + 2) % 6]},
                     '{v[(k + 3) % 6], v[(k + 4) % 6], v[(k + 5) % 6]}, 3'(k));
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = 0;
        i_cfg_data = 0;
        box_if.valid = 0;
        box_if.box_min_x = 0;
        box_if.box_min_y = 0;
        box_if.box_min_z = 0;
        box_if.box_max_x = 0;
        box_if.box_max_y = 0;
        box_if.box_max_z = 0;
        box_if.axes_to_test = 0;
        res_if.ready = 0;
        cycles = 0;
        stim_done = 0;
        send_idle = 38;
        recv_idle = 51;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        directed();
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle = 51;
                recv_idle = 38;
            end else if (ph == 4) begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (ph == 1) begin
                // w column coefficients negative: extreme coefficients
                for (int r = 0; r < 8; r++)
                    write_reg(r, {32'h8000_0000, 32'h7fff_ffff});
            end else if (ph == 3) begin
                for (int r = 0; r < 8; r++) write_reg(r, 64'hffff_ffff_ffff_ffff);
            end else if (ph > 0) begin
                for (int r = 0; r < 8; r++) write_reg(r, {rand_coef(), rand_coef()});
            end
            send_random(ph == 0 ? 500 : 280);
            drain();
        end
        for (int r = 0; r < 8; r++) write_reg(r, RST_MREG[r]);
        send_random(20);
        drain();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (sb.errors == 0 && sb.exp_q.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        wait (cycles >= 400000);
        $display("testbench failed");
        $finish;
    end
endmodule
